### design/ioc_pkg.sv
package ioc_pkg;

  localparam int unsigned NumAxes      = 6;
  localparam int unsigned NumAccel     = 3;
  localparam int unsigned RawW         = 16;
  localparam int unsigned CorrW        = 17;
  localparam int unsigned SumW         = 33;
  localparam int unsigned CalW         = 16;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned AxisW        = 3;
  localparam int unsigned InDataW      = 96;
  localparam int unsigned OutDataW     = 104;
  localparam int unsigned CountBitsDef = 16;

  localparam logic [CalW-1:0] CalCountRst = 16'd100;

  localparam logic signed [RawW-1:0] HalfG = 16'sd8192;
  localparam logic signed [RawW-1:0] OneG  = 16'sd16384;

  localparam logic [CmdW-1:0] CmdMeasure = 2'd0;
  localparam logic [CmdW-1:0] CmdStart   = 2'd1;
  localparam logic [CmdW-1:0] CmdSample  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]                 cmd;
    logic [NumAxes-1:0][RawW-1:0]    raw;
  } ioc_item_t;

  typedef struct packed {
    logic [NumAxes-1:0][CorrW-1:0]   corr;
    logic                            calib_done;
  } ioc_result_t;

  // Removes one g from an accelerometer reading that is near plus or minus one g.
  function automatic logic [RawW-1:0] fold_g(input logic [RawW-1:0] raw);
    logic signed [RawW-1:0] s;
    s = $signed(raw);
    if (s > HalfG) begin
      return raw - OneG;
    end else if (s < -HalfG) begin
      return raw + OneG;
    end
    return raw;
  endfunction

endpackage

### design/ioc_serial_div.sv
module ioc_serial_div import ioc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CalW-1:0] divisor_i,
  output logic            done_o,
  output logic [RawW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(SumW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SumW-1:0]  num_q, num_d;
  logic [CalW-1:0]  rem_q, rem_d;
  logic [CalW:0]    rem_sh;
  logic [CalW:0]    rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[SumW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[SumW-1];
      num_d  = dividend_i[SumW-1] ? (~dividend_i + SumW'(1)) : dividend_i;
      rem_d  = '0;
      step_d = StepW'(SumW - 1);
    end else if (busy_q) begin
      num_d = {num_q[SumW-2:0], ge};
      rem_d = ge ? rem_sub[CalW-1:0] : rem_sh[CalW-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      step_q <= step_d;
      num_q  <= num_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~num_q[RawW-1:0] + RawW'(1)) : num_q[RawW-1:0];

endmodule

### design/ioc_core.sv
module ioc_core import ioc_pkg::*; #(
  parameter int unsigned CountBits = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  ioc_item_t   item_i,
  input  logic [CalW-1:0] calib_count_i,
  input  logic        out_free_i,
  output logic        idle_o,
  output logic        done_o,
  output ioc_result_t result_o
);

  localparam int unsigned CmpW = (CountBits > CalW) ? CountBits : CalW;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StMeas    = 3'd1;
  localparam logic [2:0] StAcc     = 3'd2;
  localparam logic [2:0] StDivGo   = 3'd3;
  localparam logic [2:0] StDivWait = 3'd4;
  localparam logic [2:0] StFin     = 3'd5;

  localparam logic [AxisW-1:0] LastAxis = AxisW'(NumAxes - 1);
  localparam logic [CountBits-1:0] CntMax = '1;

  logic [2:0]           state_q, state_d;
  logic [AxisW-1:0]     axis_q, axis_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 done_flag_q, done_flag_d;
  logic [RawW-1:0]      raw_q  [NumAxes];
  logic [RawW-1:0]      raw_d  [NumAxes];
  logic [SumW-1:0]      sums_q [NumAxes];
  logic [SumW-1:0]      sums_d [NumAxes];
  logic [RawW-1:0]      offs_q [NumAxes];
  logic [RawW-1:0]      offs_d [NumAxes];
  logic [CorrW-1:0]     corr_q [NumAxes];
  logic [CorrW-1:0]     corr_d [NumAxes];

  logic                 cnt_adv;
  logic [CountBits-1:0] cnt_inc;
  logic                 hit;
  logic [RawW-1:0]      acc_in;
  logic [SumW-1:0]      sum_new;
  logic [CorrW-1:0]     diff;
  logic                 div_start;
  logic                 div_done;
  logic [RawW-1:0]      quotient;

  assign cnt_adv = cnt_q != CntMax;
  assign cnt_inc = cnt_q + CountBits'(cnt_adv);
  assign hit     = cnt_adv && (calib_count_i != '0) &&
                   (CmpW'(cnt_inc) == CmpW'(calib_count_i));
  assign acc_in  = (axis_q < AxisW'(NumAccel)) ? fold_g(raw_q[0]) : raw_q[0];
  assign sum_new = sums_q[0] + {{(SumW - RawW){acc_in[RawW-1]}}, acc_in};
  assign diff    = {raw_q[0][RawW-1], raw_q[0]} - {offs_q[0][RawW-1], offs_q[0]};

  assign div_start = state_q == StDivGo;

  ioc_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[0]),
    .divisor_i  (calib_count_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    done_flag_d = done_flag_q;
    raw_d       = raw_q;
    sums_d      = sums_q;
    offs_d      = offs_q;
    corr_d      = corr_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          axis_d      = '0;
          done_flag_d = 1'b0;
          for (int i = 0; i < NumAxes; i++) begin
            raw_d[i]  = item_i.raw[i];
            corr_d[i] = '0;
          end
          case (item_i.cmd)
            CmdMeasure: state_d = StMeas;
            CmdSample:  state_d = StAcc;
            CmdStart: begin
              for (int i = 0; i < NumAxes; i++) begin
                sums_d[i] = '0;
              end
              cnt_d   = '0;
              state_d = StFin;
            end
            default: state_d = StFin;
          endcase
        end
      end
      StMeas: begin
        for (int i = 0; i < NumAxes - 1; i++) begin
          raw_d[i]  = raw_q[i+1];
          offs_d[i] = offs_q[i+1];
          corr_d[i] = corr_q[i+1];
        end
        raw_d[NumAxes-1]  = raw_q[0];
        offs_d[NumAxes-1] = offs_q[0];
        corr_d[NumAxes-1] = diff;
        axis_d = axis_q + AxisW'(1);
        if (axis_q == LastAxis) begin
          state_d = StFin;
        end
      end
      StAcc: begin
        for (int i = 0; i < NumAxes - 1; i++) begin
          raw_d[i]  = raw_q[i+1];
          sums_d[i] = sums_q[i+1];
        end
        raw_d[NumAxes-1]  = raw_q[0];
        sums_d[NumAxes-1] = sum_new;
        axis_d = axis_q + AxisW'(1);
        if (axis_q == LastAxis) begin
          cnt_d  = cnt_inc;
          axis_d = '0;
          state_d = hit ? StDivGo : StFin;
        end
      end
      StDivGo: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_done) begin
          for (int i = 0; i < NumAxes - 1; i++) begin
            sums_d[i] = sums_q[i+1];
            offs_d[i] = offs_q[i+1];
          end
          sums_d[NumAxes-1] = sums_q[0];
          offs_d[NumAxes-1] = quotient;
          axis_d = axis_q + AxisW'(1);
          if (axis_q == LastAxis) begin
            done_flag_d = 1'b1;
            state_d     = StFin;
          end else begin
            state_d = StDivGo;
          end
        end
      end
      StFin: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= '0;
      cnt_q       <= '0;
      done_flag_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        sums_q[i] <= '0;
        offs_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      done_flag_q <= done_flag_d;
      sums_q      <= sums_d;
      offs_q      <= offs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    corr_q <= corr_d;
  end

  assign idle_o = state_q == StIdle;
  assign done_o = (state_q == StFin) && out_free_i;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      result_o.corr[i] = corr_q[i];
    end
    result_o.calib_done = done_flag_q;
  end

endmodule

### design/imu_offset_calibrate_correct.sv
// Six-axis IMU bias calibration and correction. A word carries a command in tuser
// (0 measure, 1 start calibration, 2 calibration sample) and six signed 16-bit axes
// in tdata; every accepted word yields exactly one output word. A measure or an
// ordinary calibration sample rotates the six axes one per cycle through a single
// adder. The calibration sample that reaches calib_count also runs the six averages
// through one bit-serial divider, one axis after another. The next input word is
// taken as soon as the previous result sits in the output register.
module imu_offset_calibrate_correct import ioc_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CalW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // command
  input  logic [CmdW-1:0]     s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // accel_x_corr, accel_y_corr, accel_z_corr, gyro_x_corr, gyro_y_corr, gyro_z_corr
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // calib_done
  output logic                m_axis_tuser_o
);

  logic [CalW-1:0] calib_count_q;
  logic            m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic            m_user_q, m_user_d;
  logic            idle;
  logic            core_done;
  logic            out_free;
  logic            start;
  ioc_item_t       item;
  ioc_result_t     result;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign start    = s_axis_tvalid_i && idle;

  always_comb begin
    item.cmd = s_axis_tuser_i;
    for (int i = 0; i < NumAxes; i++) begin
      item.raw[i] = s_axis_tdata_i[RawW*i +: RawW];
    end
  end

  ioc_core #(
    .CountBits (COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .item_i        (item),
    .calib_count_i (calib_count_q),
    .out_free_i    (out_free),
    .idle_o        (idle),
    .done_o        (core_done),
    .result_o      (result)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (core_done) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      for (int i = 0; i < NumAxes; i++) begin
        m_data_d[CorrW*i +: CorrW] = result.corr[i];
      end
      m_user_d = result.calib_done;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_count_q <= CalCountRst;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        calib_count_q <= cfg_wdata_i;
      end
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign s_axis_tready_o = idle;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import ioc_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned RandomWords = 1600;
  localparam int unsigned LargeRunWords = 100;
  localparam int unsigned MaxReports = 30;

  typedef logic [NumAxes-1:0][RawW-1:0] axes_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CalW-1:0]     cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [CmdW-1:0]     s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  // Shadow copy of the calibration state.
  logic [CalW-1:0]          avg_target;
  logic [CountBitsDef-1:0]  avg_seen;
  logic signed [RawW-1:0]   bias [NumAxes];
  logic signed [SumW-1:0]   bias_sum [NumAxes];

  ioc_result_t corrected_q [$];
  ioc_result_t want;

  bit          idle_on = 1'b1;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_words = 0;
  int unsigned n_measure = 0;
  int unsigned n_done = 0;
  int          chk_k;

  string axis_name [NumAxes] = '{"accel_x_corr", "accel_y_corr", "accel_z_corr",
                                 "gyro_x_corr", "gyro_y_corr", "gyro_z_corr"};

  imu_offset_calibrate_correct u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void reset_model();
    int i;
    avg_target = CalCountRst;
    avg_seen = '0;
    for (i = 0; i < NumAxes; i++) begin
      bias[i] = '0;
      bias_sum[i] = '0;
    end
  endfunction

  // Updates the shadow state for one accepted word and returns the word it must produce.
  function automatic ioc_result_t apply_word(logic [CmdW-1:0] cmd, axes_t raw);
    ioc_result_t res;
    logic signed [RawW-1:0] v;
    logic signed [SumW-1:0] divisor;
    logic signed [SumW-1:0] quot;
    logic stepped;
    int i;
    res = '0;
    stepped = 1'b0;
    case (cmd)
      CmdMeasure: begin
        for (i = 0; i < NumAxes; i++) begin
          res.corr[i] = {raw[i][RawW-1], raw[i]} - {bias[i][RawW-1], bias[i]};
        end
      end
      CmdStart: begin
        for (i = 0; i < NumAxes; i++) begin
          bias_sum[i] = '0;
        end
        avg_seen = '0;
      end
      CmdSample: begin
        for (i = 0; i < NumAxes; i++) begin
          v = raw[i];
          if (i < NumAccel) begin
            if (v > HalfG) begin
              v = v - OneG;
            end else if (v < -HalfG) begin
              v = v + OneG;
            end
          end
          bias_sum[i] = bias_sum[i] + {{(SumW-RawW){v[RawW-1]}}, v};
        end
        if (avg_seen != '1) begin
          avg_seen = avg_seen + 1'b1;
          stepped = 1'b1;
        end
        if (stepped && avg_target != '0 && avg_seen == avg_target) begin
          divisor = {{(SumW-CalW){1'b0}}, avg_target};
          for (i = 0; i < NumAxes; i++) begin
            quot = bias_sum[i] / divisor;
            bias[i] = quot[RawW-1:0];
          end
          res.calib_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic axes_t pack_axes(int ax, int ay, int az, int gx, int gy, int gz);
    return {16'(gz), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  // Mostly plausible readings: accelerometer near 0 or plus or minus 1 g, gyroscope near rest.
  function automatic axes_t gen_sample();
    axes_t a;
    int v;
    int i;
    if ($urandom_range(0, 7) == 0) begin
      return {$urandom, $urandom, $urandom};
    end
    for (i = 0; i < NumAxes; i++) begin
      if (i < NumAccel) begin
        case ($urandom_range(0, 2))
          0: v = int'(OneG);
          1: v = -int'(OneG);
          default: v = 0;
        endcase
        v = v + int'($urandom_range(0, 4000)) - 2000;
      end else begin
        v = int'($urandom_range(0, 1000)) - 500 + 300 * i;
      end
      a[i] = v[RawW-1:0];
    end
    return a;
  endfunction

  task automatic send_word(logic [CmdW-1:0] cmd, axes_t raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    corrected_q.push_back(apply_word(cmd, raw));
    n_words++;
    if (cmd == CmdMeasure) begin
      n_measure++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (corrected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_calib(logic [CalW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    avg_target = value;
  endtask

  task automatic note_mismatch(string what, int expv, int actv);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
    end
  endtask

  always begin
    @(posedge clk_i);
    if (rst_ni && idle_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    m_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (corrected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: output word with nothing expected, expected none, got %h / %b",
                   $time, m_tdata, m_tuser);
        end
      end else begin
        want = corrected_q.pop_front();
        for (chk_k = 0; chk_k < NumAxes; chk_k++) begin
          if (m_tdata[chk_k*CorrW +: CorrW] !== want.corr[chk_k]) begin
            note_mismatch(axis_name[chk_k], int'($signed(want.corr[chk_k])),
                          int'($signed(m_tdata[chk_k*CorrW +: CorrW])));
          end
        end
        if (m_tuser !== want.calib_done) begin
          note_mismatch("calib_done", int'(want.calib_done), int'(m_tuser));
        end
        if (want.calib_done) begin
          n_done++;
        end
      end
    end
  end

  // Offsets are zero after reset, so measurements pass the raw values through.
  task automatic test_uncalibrated();
    send_word(CmdMeasure, pack_axes(32767, 32767, 32767, 32767, 32767, 32767));
    send_word(CmdMeasure, pack_axes(-32768, -32768, -32768, -32768, -32768, -32768));
    send_word(CmdMeasure, '0);
    send_word(CmdUnused, {NumAxes{16'hFFFF}});
    send_word(CmdMeasure, {3{16'h5555, 16'hAAAA}});
    drain();
  endtask

  // Gravity folding at its thresholds, full-scale gyro averages and full-scale correction.
  task automatic test_fold_and_average();
    write_calib(16'd3);
    send_word(CmdStart, '0);
    send_word(CmdSample, pack_axes(8192, 8193, -8192, 32767, -32768, 1));
    send_word(CmdSample, pack_axes(-8193, 32767, -32768, 32767, -32768, -1));
    send_word(CmdSample, pack_axes(16384, -16384, 0, 32767, -32768, -2));
    send_word(CmdSample, pack_axes(100, -100, 200, 5, -5, 7));
    send_word(CmdMeasure, pack_axes(-32768, 32767, 0, -32768, 32767, 0));
    send_word(CmdStart, '0);
    send_word(CmdUnused, pack_axes(1, 2, 3, 4, 5, 6));
    send_word(CmdMeasure, pack_axes(32767, -32768, 1, 32767, -32768, -1));
    drain();
  endtask

  // A count of one completes at once, a count of two shows truncation toward zero,
  // and a count of zero never completes.
  task automatic test_small_counts();
    write_calib(16'd1);
    send_word(CmdStart, '0);
    send_word(CmdSample, pack_axes(9000, -9000, 16000, 40, -40, 0));
    send_word(CmdMeasure, pack_axes(0, 0, 0, 0, 0, 0));
    write_calib(16'd2);
    send_word(CmdStart, '0);
    send_word(CmdSample, pack_axes(3, -3, -1, -1, 1, -2));
    send_word(CmdSample, pack_axes(0, 0, -2, -2, 2, -3));
    send_word(CmdMeasure, pack_axes(0, 0, 0, 0, 0, 0));
    write_calib(16'd0);
    send_word(CmdStart, '0);
    repeat (3) send_word(CmdSample, gen_sample());
    send_word(CmdMeasure, gen_sample());
    drain();
  endtask

  task automatic test_random_runs();
    int unsigned stop_at;
    int unsigned runs;
    int unsigned p;
    int k;
    logic [CalW-1:0] target;
    stop_at = n_words + RandomWords;
    while (n_words < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      p = $urandom_range(0, 19);
      if (p == 0) begin
        target = '0;
      end else if (p < 14) begin
        target = CalW'($urandom_range(1, 20));
      end else if (p < 18) begin
        target = CalW'($urandom_range(21, 80));
      end else begin
        target = CalW'($urandom_range(81, 250));
      end
      write_calib(target);
      send_word(CmdStart, gen_sample());
      runs = int'(target) + $urandom_range(0, 3);
      for (k = 0; k < runs; k++) begin
        p = $urandom_range(0, 99);
        if (p == 0) begin
          send_word(CmdStart, gen_sample());
        end else if (p < 3) begin
          send_word(CmdUnused, gen_sample());
        end else if (p < 15) begin
          send_word(CmdMeasure, gen_sample());
        end else begin
          send_word(CmdSample, gen_sample());
        end
      end
      repeat ($urandom_range(1, 6)) send_word(CmdMeasure, gen_sample());
    end
    drain();
  endtask

  // With the largest count a long run of samples never completes, so the offsets
  // stay as they were.
  task automatic test_large_count();
    idle_on = 1'b0;
    write_calib('1);
    send_word(CmdStart, '0);
    repeat (LargeRunWords) send_word(CmdSample, gen_sample());
    repeat (3) send_word(CmdMeasure, gen_sample());
    drain();
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_uncalibrated();
    test_fold_and_average();
    test_small_counts();
    test_random_runs();
    test_large_count();
    drain();
    repeat (250) @(posedge clk_i);
    $display("Run covered %0d words, %0d of them measurements, and %0d completed averages,",
             n_words, n_measure, n_done);
    $display("with counts from zero up to the largest value and random stalls.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### imu_offset_calibrate_correct.f
design/ioc_pkg.sv
design/ioc_serial_div.sv
design/ioc_core.sv
design/imu_offset_calibrate_correct.sv
sim/tb.sv
